// ----- rtl/alu32_pkg.sv -----
package alu32_pkg;

   localparam int QueueDepth = 4;

   typedef enum logic [3:0] {
      FN_ADD = 4'd0,
      FN_SUB = 4'd1,
      FN_MUL = 4'd2,
      FN_DIV = 4'd3,
      FN_LSR = 4'd4,
      FN_LSL = 4'd5,
      FN_ASR = 4'd6,
      FN_AND = 4'd7,
      FN_OR  = 4'd8,
      FN_XOR = 4'd9,
      FN_NEG = 4'd10,
      FN_NOT = 4'd11
   } func_type;

   typedef enum logic [1:0] {
      CLS_SINGLE  = 2'd0,
      CLS_DIV     = 2'd1,
      CLS_DIVZERO = 2'd2
   } class_type;

   typedef enum logic {
      BACK_RUN = 1'b0,
      BACK_DIV = 1'b1
   } back_state_type;

   typedef struct packed {
      logic [3:0]  func;
      logic [31:0] operand_a;
      logic [31:0] operand_b;
   } req_type;

   typedef struct packed {
      logic [31:0] result;
      logic        divide_error;
   } rsp_type;

   typedef struct packed {
      class_type cls;
      req_type   req;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

// ----- rtl/integer_alu_32bit_core.sv -----
// 32-bit integer alu. A request is taken when start is high and busy is low and lands in a
// queue of QUEUE_DEPTH entries; results leave in request order, for one cycle on rsp_strobe,
// from a register loaded as the execute stage finishes a request. The receiver cannot
// stall, so each result must be captured in the cycle it is shown. Every operation except
// divide is computed as it leaves the queue, so such requests stream at one per clock while
// no divide holds the execute stage. An unsigned divide with a nonzero divisor runs on a
// radix-2 restoring divider, one quotient bit per cycle, and holds the execute stage until
// its quotient is done; requests keep queuing meanwhile and busy rises only when the queue
// is full. A divide by zero returns zero with divide_error set, without entering the divider.
module integer_alu_32bit_core #(
   parameter int QUEUE_DEPTH = alu32_pkg::QueueDepth
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  alu32_pkg::req_type req_data,
   output logic               rsp_strobe,
   output alu32_pkg::rsp_type rsp_data
);

   logic                        push;
   logic                        pop;
   alu32_pkg::entry_type        push_entry;
   alu32_pkg::entry_type        head_entry;
   alu32_pkg::queue_status_type status;

   alu32_front u_front (
      .start      (start),
      .queue_full (status.full),
      .req_data   (req_data),
      .push       (push),
      .push_entry (push_entry)
   );

   alu32_queue #(
      .Depth (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (status)
   );

   alu32_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .status     (status),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   assign busy = status.full;

endmodule

// ----- rtl/alu32_front.sv -----
module alu32_front (
   input  logic              start,
   input  logic              queue_full,
   input  alu32_pkg::req_type req_data,
   output logic              push,
   output alu32_pkg::entry_type push_entry
);

   always_comb begin
      push = start && !queue_full;
      push_entry.req = req_data;
      if (req_data.func == alu32_pkg::FN_DIV) begin
         push_entry.cls = (req_data.operand_b == 32'd0) ? alu32_pkg::CLS_DIVZERO
                                                        : alu32_pkg::CLS_DIV;
      end else begin
         push_entry.cls = alu32_pkg::CLS_SINGLE;
      end
   end

endmodule

// ----- rtl/alu32_queue.sv -----
module alu32_queue #(
   parameter int Depth = alu32_pkg::QueueDepth
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  alu32_pkg::entry_type        push_entry,
   input  logic                        pop,
   output alu32_pkg::entry_type        head_entry,
   output alu32_pkg::queue_status_type status
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   alu32_pkg::entry_type mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry   = mem_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == FullCnt);

endmodule

// ----- rtl/alu32_back.sv -----
module alu32_back (
   input  logic                        clock,
   input  logic                        reset,
   input  alu32_pkg::entry_type        head_entry,
   input  alu32_pkg::queue_status_type status,
   output logic                        pop,
   output logic                        rsp_strobe,
   output alu32_pkg::rsp_type          rsp_data
);

   alu32_pkg::back_state_type state_ff, state_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] dvs_ff, dvs_in;
   logic        rsp_strobe_ff, rsp_strobe_in;
   alu32_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic        load_div;
   logic        emit_now;
   logic        emit_div;
   logic [32:0] shifted;
   logic [32:0] diff;
   logic        fits;
   alu32_pkg::rsp_type single;
   logic [31:0] a;
   logic [31:0] b;
   logic [4:0]  sh;

   // one bit of restoring division per cycle
   always_comb begin
      shifted = {rem_ff, quo_ff[31]};
      diff    = shifted - {1'b0, dvs_ff};
      fits    = !diff[32];
   end

   always_comb begin
      a  = head_entry.req.operand_a;
      b  = head_entry.req.operand_b;
      sh = b[4:0];
      single.divide_error = 1'b0;
      unique case (head_entry.req.func)
         alu32_pkg::FN_ADD: single.result = a + b;
         alu32_pkg::FN_SUB: single.result = a - b;
         alu32_pkg::FN_MUL: single.result = a * b;
         alu32_pkg::FN_DIV: begin
            single.result       = 32'd0;
            single.divide_error = (head_entry.cls == alu32_pkg::CLS_DIVZERO);
         end
         alu32_pkg::FN_LSR: single.result = a >> sh;
         alu32_pkg::FN_LSL: single.result = a << sh;
         alu32_pkg::FN_ASR: single.result = $unsigned($signed(a) >>> sh);
         alu32_pkg::FN_AND: single.result = a & b;
         alu32_pkg::FN_OR:  single.result = a | b;
         alu32_pkg::FN_XOR: single.result = a ^ b;
         alu32_pkg::FN_NEG: single.result = 32'd0 - a;
         alu32_pkg::FN_NOT: single.result = ~a;
         default:           single.result = 32'd0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         alu32_pkg::BACK_RUN: begin
            if (!status.empty && head_entry.cls == alu32_pkg::CLS_DIV) begin
               state_in = alu32_pkg::BACK_DIV;
            end
         end
         alu32_pkg::BACK_DIV: begin
            if (cnt_ff == 5'd0) begin
               state_in = alu32_pkg::BACK_RUN;
            end
         end
         default: state_in = alu32_pkg::BACK_RUN;
      endcase
   end

   always_comb begin
      pop      = 1'b0;
      load_div = 1'b0;
      emit_now = 1'b0;
      emit_div = 1'b0;
      unique case (state_ff)
         alu32_pkg::BACK_RUN: begin
            pop      = !status.empty;
            load_div = !status.empty && head_entry.cls == alu32_pkg::CLS_DIV;
            emit_now = !status.empty && head_entry.cls != alu32_pkg::CLS_DIV;
         end
         alu32_pkg::BACK_DIV: begin
            emit_div = (cnt_ff == 5'd0);
         end
         default: ;
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      if (load_div) begin
         cnt_in = 5'd31;
         rem_in = 32'd0;
         quo_in = head_entry.req.operand_a;
         dvs_in = head_entry.req.operand_b;
      end else if (state_ff == alu32_pkg::BACK_DIV) begin
         cnt_in = cnt_ff - 5'd1;
         rem_in = fits ? diff[31:0] : shifted[31:0];
         quo_in = {quo_ff[30:0], fits};
      end
      rsp_strobe_in = emit_now || emit_div;
      if (emit_div) begin
         rsp_data_in.result       = {quo_ff[30:0], fits};
         rsp_data_in.divide_error = 1'b0;
      end else begin
         rsp_data_in = single;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= alu32_pkg::BACK_RUN;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      dvs_ff      <= dvs_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// ----- rtl/alu32_checker.sv -----
module alu32_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input alu32_pkg::req_type req_data,
   input logic               rsp_strobe,
   input alu32_pkg::rsp_type rsp_data
);

   // nothing left over from before reset
   assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("result strobe right after reset");

   assert property (@(posedge clock) reset |=> !busy)
      else $error("busy right after reset");

   // a divide error always carries a zero result
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.divide_error |-> rsp_data.result == 32'd0)
      else $error("divide error with nonzero result");

   // the queue only fills when a request is taken
   assert property (@(posedge clock) disable iff (reset)
      !busy && !start |=> !busy)
      else $error("busy without a request");

   // an accepted request carries known data
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> !$isunknown(req_data))
      else $error("unknown request data accepted");

endmodule

bind integer_alu_32bit_core alu32_checker u_alu32_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

// ----- tb/testbench.sv -----
module testbench;

   localparam int RandomCount = 1250;
   localparam int CycleLimit  = 200000;
   localparam logic [3:0] FnUnusedLow  = 4'd12;
   localparam logic [3:0] FnUnusedHigh = 4'd15;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   alu32_pkg::req_type req_data;
   logic               rsp_strobe;
   alu32_pkg::rsp_type rsp_data;

   alu32_pkg::rsp_type pending_results[$];
   int                 mismatches;
   int                 cycles;
   bit                 quiet_phase;

   integer_alu_32bit_core DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic alu32_pkg::rsp_type alu_compute(alu32_pkg::req_type r);
      alu32_pkg::rsp_type o;
      logic [63:0]        prod;
      logic [4:0]         sh;
      sh = r.operand_b[4:0];
      o.result = '0;
      o.divide_error = 1'b0;
      case (r.func)
         alu32_pkg::FN_ADD: o.result = r.operand_a + r.operand_b;
         alu32_pkg::FN_SUB: o.result = r.operand_a - r.operand_b;
         alu32_pkg::FN_MUL: begin
            prod = r.operand_a * r.operand_b;
            o.result = prod[31:0];
         end
         alu32_pkg::FN_DIV: begin
            if (r.operand_b == '0) o.divide_error = 1'b1;
            else o.result = r.operand_a / r.operand_b;
         end
         alu32_pkg::FN_LSR: o.result = r.operand_a >> sh;
         alu32_pkg::FN_LSL: o.result = r.operand_a << sh;
         alu32_pkg::FN_ASR: o.result = $unsigned($signed(r.operand_a) >>> sh);
         alu32_pkg::FN_AND: o.result = r.operand_a & r.operand_b;
         alu32_pkg::FN_OR:  o.result = r.operand_a | r.operand_b;
         alu32_pkg::FN_XOR: o.result = r.operand_a ^ r.operand_b;
         alu32_pkg::FN_NEG: o.result = -r.operand_a;
         alu32_pkg::FN_NOT: o.result = ~r.operand_a;
         default: ;
      endcase
      return o;
   endfunction

   // check results and count cycles at the rising edge
   always @(posedge clock) begin
      alu32_pkg::rsp_type exp_rsp;
      cycles <= cycles + 1;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
               $display("unexpected result %h err %b", rsp_data.result, rsp_data.divide_error);
         end else begin
            exp_rsp = pending_results.pop_front();
            if (rsp_data.result !== exp_rsp.result ||
                rsp_data.divide_error !== exp_rsp.divide_error) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("mismatch: expected %h/%b, got %h/%b", exp_rsp.result,
                           exp_rsp.divide_error, rsp_data.result, rsp_data.divide_error);
            end
         end
      end
   end

   initial begin
      @(posedge clock);
      while (cycles < CycleLimit) @(posedge clock);
      $display("integer_alu_32bit_core verification failed");
      $finish;
   end

   // one request; expectation given when it can be read off directly
   task automatic send_request(alu32_pkg::req_type r, bit has_exp,
                               alu32_pkg::rsp_type exp_rsp);
      int gap;
      if (!quiet_phase && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 18);
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      // busy is registered, so its value here holds through the next rising edge
      while (busy) @(negedge clock);
      @(posedge clock);
      pending_results.push_back(has_exp ? exp_rsp : alu_compute(r));
      @(negedge clock);
   endtask

   function automatic alu32_pkg::req_type random_request();
      alu32_pkg::req_type r;
      logic [31:0] picks[6] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h8000_0000,
                                32'h7FFF_FFFF, 32'h0};
      r.func = 4'($urandom_range(0, 15));
      r.operand_a = $urandom();
      r.operand_b = $urandom();
      case ($urandom_range(0, 7))
         0: r.operand_a = picks[$urandom_range(0, 4)];
         1: r.operand_b = picks[$urandom_range(0, 4)];
         2: r.operand_b = $urandom_range(0, 70);
         3: r.operand_b = $urandom() >> $urandom_range(0, 31);
         default: ;
      endcase
      return r;
   endfunction

   typedef struct {
      alu32_pkg::req_type r;
      bit                 has_exp;
      alu32_pkg::rsp_type e;
   } stim_row_type;

   initial begin
      stim_row_type       rows[$];
      alu32_pkg::req_type r;
      int                 n;
      start = 1'b0;
      req_data = '0;
      mismatches = 0;
      cycles = 0;
      quiet_phase = 1'b0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      rows.push_back('{'{alu32_pkg::FN_ADD, 32'hFFFF_FFFF, 32'h1}, 1, '{32'h0, 1'b0}});
      rows.push_back('{'{alu32_pkg::FN_SUB, 32'h0, 32'h1}, 1, '{32'hFFFF_FFFF, 1'b0}});
      rows.push_back('{'{alu32_pkg::FN_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1,
                       '{32'h1, 1'b0}});
      rows.push_back('{'{alu32_pkg::FN_DIV, 32'h1234_5678, 32'h0}, 1, '{32'h0, 1'b1}});
      rows.push_back('{'{alu32_pkg::FN_DIV, 32'hFFFF_FFFF, 32'h1}, 1,
                       '{32'hFFFF_FFFF, 1'b0}});
      rows.push_back('{'{alu32_pkg::FN_DIV, 32'h7, 32'hFFFF_FFFF}, 1, '{32'h0, 1'b0}});
      rows.push_back('{'{alu32_pkg::FN_LSR, 32'h8000_0000, 32'd31}, 1, '{32'h1, 1'b0}});
      rows.push_back('{'{alu32_pkg::FN_LSR, 32'hF000_0000, 32'd36}, 0, '{32'h0, 1'b0}});
      rows.push_back('{'{alu32_pkg::FN_LSL, 32'h1, 32'd32}, 1, '{32'h1, 1'b0}});
      rows.push_back('{'{alu32_pkg::FN_LSL, 32'h1, 32'd31}, 1, '{32'h8000_0000, 1'b0}});
      rows.push_back('{'{alu32_pkg::FN_ASR, 32'h8000_0000, 32'd31}, 1,
                       '{32'hFFFF_FFFF, 1'b0}});
      rows.push_back('{'{alu32_pkg::FN_ASR, 32'h8000_0000, 32'd0}, 1,
                       '{32'h8000_0000, 1'b0}});
      rows.push_back('{'{alu32_pkg::FN_ASR, 32'h7FFF_FFFF, 32'hFFFF_FFE4}, 0,
                       '{32'h0, 1'b0}});
      rows.push_back('{'{alu32_pkg::FN_AND, 32'hFFFF_FFFF, 32'hA5A5_5A5A}, 1,
                       '{32'hA5A5_5A5A, 1'b0}});
      rows.push_back('{'{alu32_pkg::FN_OR, 32'h0, 32'hFFFF_FFFF}, 1, '{32'hFFFF_FFFF, 1'b0}});
      rows.push_back('{'{alu32_pkg::FN_XOR, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1,
                       '{32'h0, 1'b0}});
      rows.push_back('{'{alu32_pkg::FN_NEG, 32'h8000_0000, 32'hFFFF_FFFF}, 1,
                       '{32'h8000_0000, 1'b0}});
      rows.push_back('{'{alu32_pkg::FN_NEG, 32'h1, 32'h0}, 1, '{32'hFFFF_FFFF, 1'b0}});
      rows.push_back('{'{alu32_pkg::FN_NOT, 32'h0, 32'h1234_5678}, 1,
                       '{32'hFFFF_FFFF, 1'b0}});
      // unused codes return zero without error
      rows.push_back('{'{FnUnusedLow, 32'hFFFF_FFFF, 32'h0}, 1, '{32'h0, 1'b0}});
      rows.push_back('{'{FnUnusedHigh, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1, '{32'h0, 1'b0}});
      rows.push_back('{'{alu32_pkg::FN_DIV, 32'h0, 32'h0}, 1, '{32'h0, 1'b1}});

      foreach (rows[i]) send_request(rows[i].r, rows[i].has_exp, rows[i].e);

      for (n = 0; n < RandomCount; n++) begin
         if (n == RandomCount / 2) begin
            // let the block drain completely before continuing
            start <= 1'b0;
            while (pending_results.size() != 0) @(negedge clock);
         end
         if (n == RandomCount - 150) quiet_phase = 1'b1;
         r = random_request();
         send_request(r, 0, '{32'h0, 1'b0});
      end
      start <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("integer_alu_32bit_core verification clean");
      else
         $display("integer_alu_32bit_core verification failed");
      $finish;
   end

endmodule
